/* sv/lrrg_pkg.sv */
// ---------------------------------------------------------------------------
// lrrg_pkg: shared types and constants for the Lehmer range generator
// Holds the generator constants, the action codes and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package lrrg_pkg;

  // Lehmer generator: seed' = seed * 48271 mod (2^31 - 1)
  localparam int unsigned DRAW_W    = 31;
  localparam int unsigned MULT_W    = 16;
  localparam int unsigned PROD_W    = DRAW_W + MULT_W;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned BOUND_W   = DATA_W + 1;
  localparam int unsigned ACC_W     = DATA_W + 2;
  localparam int unsigned DIV_CNT_W = $clog2(DRAW_W);

  localparam logic [MULT_W-1:0] LCG_MULT = 16'd48271;
  localparam logic [DRAW_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

  // seed folding modulus 2^31 - 2
  localparam logic signed [ACC_W-1:0] FOLD_MOD = 34'sd2147483646;

  // narrow spans take the draw modulo the span
  localparam int unsigned SMALL_SPAN_LIMIT_LOG2 = 20;
  localparam logic [DATA_W-1:0] SMALL_TOP_LIMIT =
    DATA_W'((64'd1 << SMALL_SPAN_LIMIT_LOG2) - 64'd1);

  // percentage test draws in 1..100
  localparam logic signed [BOUND_W-1:0] PERCENT_LOW  = 33'sd1;
  localparam logic signed [BOUND_W-1:0] PERCENT_HIGH = 33'sd100;

  // high - low when the span wraps to zero
  localparam logic signed [ACC_W-1:0] ZERO_SPAN_DIFF = 34'sh0_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_CHOICE = 2'd2,
    ACT_TRUTH  = 2'd3
  } lrrg_action_t;

  typedef struct packed {
    logic load;
    logic fold_step;
    logic fold_commit;
    logic mul;
    logic reduce;
    logic setup;
    logic div_start;
    logic div_step;
    logic take_x;
    logic out_load;
  } lrrg_cmd_t;

  typedef struct packed {
    logic fold_done;
    logic range_err;
    logic narrow;
    logic x_fits;
  } lrrg_status_t;

endpackage

/* sv/lrrg_dp.sv */
// ---------------------------------------------------------------------------
// lrrg_dp: datapath of the Lehmer range generator
// Seed register, 31x16 multiplier with Mersenne reduction, seed folder,
// bit-serial remainder unit, span mask and the result register.
// ---------------------------------------------------------------------------
module lrrg_dp import lrrg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lrrg_cmd_t                cmd,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] first_value,
  input  logic signed [DATA_W-1:0] second_value,
  input  logic [PCT_W-1:0]         percent_true,
  output lrrg_status_t             status,
  output logic signed [DATA_W-1:0] value,
  output logic                     truth,
  output logic                     range_error
);

  logic [DRAW_W-1:0]         seed;
  logic [PROD_W-1:0]         prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [BOUND_W-1:0] low;
  logic signed [BOUND_W-1:0] high;
  logic [PCT_W-1:0]          pct;
  lrrg_action_t              op;
  logic [DATA_W-1:0]         top;
  logic [DATA_W-1:0]         mask;
  logic                      err;
  logic                      narrow;
  logic [DATA_W-1:0]         x;
  logic [DRAW_W-1:0]         sh;

  logic signed [ACC_W-1:0]   diff;
  logic [DATA_W-1:0]         mask_next;
  logic [DATA_W-1:0]         red_sum;
  logic [DRAW_W-1:0]         seed_next;
  logic [DATA_W-1:0]         masked;
  logic [DATA_W-1:0]         span;
  logic [DATA_W-1:0]         trial;
  logic [DATA_W-1:0]         choice;

  // span bounds and error check
  assign diff = ACC_W'(high) - ACC_W'(low);
  assign status.range_err = diff[ACC_W-1] || (diff == ZERO_SPAN_DIFF);
  assign status.fold_done = !acc[ACC_W-1] && (acc < FOLD_MOD);
  assign status.narrow    = narrow;

  // smallest all-ones mask covering high - low
  always_comb begin
    mask_next = diff[DATA_W-1:0];
    mask_next = mask_next | (mask_next >> 1);
    mask_next = mask_next | (mask_next >> 2);
    mask_next = mask_next | (mask_next >> 4);
    mask_next = mask_next | (mask_next >> 8);
    mask_next = mask_next | (mask_next >> 16);
  end

  // Mersenne reduction of the registered product
  always_comb begin
    red_sum = {1'b0, prod[DRAW_W-1:0]} + DATA_W'(prod[PROD_W-1:DRAW_W]);
    if (red_sum >= {1'b0, LCG_MOD}) begin
      red_sum = red_sum - {1'b0, LCG_MOD};
    end
    seed_next = red_sum[DRAW_W-1:0];
  end

  // rejection test for wide spans
  assign masked        = {1'b0, seed} & mask;
  assign status.x_fits = (masked <= top);

  // one restoring remainder step
  assign span  = top + DATA_W'(1);
  assign trial = {x[DATA_W-2:0], sh[DRAW_W-1]};

  assign choice = low[DATA_W-1:0] + x;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= DRAW_W'(1);
    end else if (cmd.fold_commit) begin
      seed <= acc[DRAW_W-1:0] + DRAW_W'(1);
    end else if (cmd.reduce) begin
      seed <= seed_next;
    end
  end

  // operand capture, fold, multiply, span setup and remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= lrrg_action_t'(action);
      pct <= percent_true;
      acc <= ACC_W'(first_value) - ACC_W'(1);
      if (lrrg_action_t'(action) == ACT_TRUTH) begin
        low  <= PERCENT_LOW;
        high <= PERCENT_HIGH;
      end else begin
        low  <= BOUND_W'(first_value);
        high <= BOUND_W'(second_value);
      end
    end else if (cmd.fold_step) begin
      if (acc[ACC_W-1]) begin
        acc <= acc + FOLD_MOD;
      end else begin
        acc <= acc - FOLD_MOD;
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(seed) * PROD_W'(LCG_MULT);
    end
    if (cmd.setup) begin
      top    <= diff[DATA_W-1:0];
      mask   <= mask_next;
      err    <= status.range_err;
      narrow <= (diff[DATA_W-1:0] < SMALL_TOP_LIMIT);
    end
    if (cmd.div_start) begin
      sh <= seed;
      x  <= '0;
    end else if (cmd.div_step) begin
      sh <= {sh[DRAW_W-2:0], 1'b0};
      if (trial >= span) begin
        x <= trial - span;
      end else begin
        x <= trial;
      end
    end else if (cmd.take_x) begin
      x <= masked;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value       <= '0;
      truth       <= 1'b0;
      range_error <= 1'b0;
      case (op)
        ACT_LOAD, ACT_RAW: begin
          value <= DATA_W'(seed);
        end
        ACT_CHOICE: begin
          if (err) begin
            range_error <= 1'b1;
          end else begin
            value <= choice;
          end
        end
        ACT_TRUTH: begin
          truth <= (choice <= DATA_W'(pct));
        end
        default: begin
          value <= '0;
        end
      endcase
    end
  end

  a_seed_range: assert property (@(posedge clk) disable iff (rst)
    (seed != '0) && (seed != LCG_MOD))
    else $error("seed left the generator range");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fold_commit |-> (!acc[ACC_W-1] && (acc < FOLD_MOD)))
    else $error("seed fold committed out of range");

  a_take_fit: assert property (@(posedge clk) disable iff (rst)
    cmd.take_x |=> (x <= top))
    else $error("wide draw taken above the span");

endmodule

/* sv/lrrg_ctrl.sv */
// ---------------------------------------------------------------------------
// lrrg_ctrl: controller of the Lehmer range generator
// Sequences seed folding, draws, rejection redraws and the remainder
// steps, and manages the result register handshake.
// ---------------------------------------------------------------------------
module lrrg_ctrl import lrrg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  logic [1:0]   action,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  input  lrrg_status_t status,
  output lrrg_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_CHECK,
    S_MUL,
    S_RED,
    S_DRAWN,
    S_DIV,
    S_FINISH
  } state_t;

  state_t               state;
  state_t               state_next;
  lrrg_action_t         op;
  logic [DIV_CNT_W-1:0] cnt;

  assign req_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (lrrg_action_t'(action))
            ACT_LOAD: state_next = S_FOLD;
            ACT_RAW:  state_next = S_MUL;
            default:  state_next = S_CHECK;
          endcase
        end
      end
      S_FOLD: begin
        if (status.fold_done) begin
          cmd.fold_commit = 1'b1;
          state_next      = S_FINISH;
        end else begin
          cmd.fold_step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        if (status.range_err) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_next = S_DRAWN;
      end
      S_DRAWN: begin
        if (op == ACT_RAW) begin
          state_next = S_FINISH;
        end else if (status.narrow) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (status.x_fits) begin
          cmd.take_x = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold state, action, step count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      op        <= ACT_LOAD;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        op <= lrrg_action_t'(action);
      end
      if (cmd.div_start) begin
        cnt <= DIV_CNT_W'(DRAW_W - 1);
      end else if (cmd.div_step) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second item accepted while busy");

  a_err_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && status.range_err) |=> (state == S_FINISH))
    else $error("range error did not skip the draw");

endmodule

/* sv/lehmer_random_range_generator_unit.sv */
// ---------------------------------------------------------------------------
// lehmer_random_range_generator_unit: Lehmer (48271, 2^31-1) range generator
// Loads a seed, draws raw values, draws values in a range, and runs a
// percentage test, one result per transfer in.
// ---------------------------------------------------------------------------
// One item is taken at a time; a finished result waits in an output
// register, so the next item can be taken while it is still stalled.
// A seed load folds the seed; a raw draw multiplies and reduces once. A
// narrow range choice and the percentage test run the 31-step bit-serial
// remainder unit that takes the draw modulo the span. A wide range choice
// draws again on the shared 31x16 multiplier for each rejected draw
// (fewer than one on average). A choice with high below low, or with the
// full 32-bit span, returns range_error and leaves the seed as it was.
module lehmer_random_range_generator_unit import lrrg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] first_value,
  input  logic signed [DATA_W-1:0] second_value,
  input  logic [PCT_W-1:0]         percent_true,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     truth,
  output logic                     range_error
);

  lrrg_cmd_t    cmd;
  lrrg_status_t status;

  // sequencer
  lrrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // seed, arithmetic and result register
  lrrg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .first_value  (first_value),
    .second_value (second_value),
    .percent_true (percent_true),
    .status       (status),
    .value        (value),
    .truth        (truth),
    .range_error  (range_error)
  );

endmodule
